// ----- design/fcsg_pkg.sv -----
// Shared types and constants for the filled circle span generator.
// No dependencies; every other design file refers to this package by scoped names.
package fcsg_pkg;

	localparam int COORD_BITS = 12;
	localparam int OUT_BITS   = 13;
	localparam int RAD_BITS   = 5;
	localparam int EXT_BITS   = 6;
	localparam int R2_BITS    = 10;
	localparam int SQ_BITS    = 12;
	localparam int MAX_RADIUS = 30;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHRINK,
		ST_EMIT_P,
		ST_EMIT_M,
		ST_EMIT_XP,
		ST_EMIT_XM
	} state_t;

	// Which of the four spans of one walk step is being produced.
	typedef enum logic [1:0] {
		SEL_P,
		SEL_M,
		SEL_XP,
		SEL_XM
	} span_sel_t;

	typedef struct packed {
		logic in_valid;
		logic gt;
		logic ndx_zero;
		logic fin;
		logic has_extra;
		logic dy_zero;
		logic slot_free;
	} stat_t;

	typedef struct packed {
		logic      ready;
		logic      load;
		logic      step;
		logic      emit;
		span_sel_t sel;
		logic      last;
		logic      commit;
		logic      mark;
	} ctrl_t;

endpackage

// ----- design/fcsg_dist_unit.sv -----
// Shared distance compare: tests radius squared against dx^2 + dy^2.
// Depends on fcsg_pkg for widths.
module fcsg_dist_unit (
	input  logic [fcsg_pkg::EXT_BITS-1:0] dx,
	input  logic [fcsg_pkg::EXT_BITS-1:0] dy,
	input  logic [fcsg_pkg::R2_BITS-1:0]  r2,
	output logic                          gt
);
	logic [fcsg_pkg::SQ_BITS-1:0] sum;

	assign sum = fcsg_pkg::SQ_BITS'(dx) * fcsg_pkg::SQ_BITS'(dx)
		+ fcsg_pkg::SQ_BITS'(dy) * fcsg_pkg::SQ_BITS'(dy);
	assign gt = fcsg_pkg::SQ_BITS'(r2) < sum;
endmodule

// ----- design/fcsg_ctrl.sv -----
// Sequencer for the span walk: load, extent shrink loop and up to four span emissions per step.
// Depends on fcsg_pkg for the state, status and control types.
module fcsg_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  fcsg_pkg::stat_t stat,
	output fcsg_pkg::ctrl_t ctrl
);
	fcsg_pkg::state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcsg_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			fcsg_pkg::ST_IDLE: begin
				if (stat.in_valid) state_nx = fcsg_pkg::ST_SHRINK;
			end
			fcsg_pkg::ST_SHRINK: begin
				if (stat.ndx_zero || !stat.gt) state_nx = fcsg_pkg::ST_EMIT_P;
			end
			fcsg_pkg::ST_EMIT_P: begin
				if (stat.slot_free) begin
					if (!stat.dy_zero) state_nx = fcsg_pkg::ST_EMIT_M;
					else if (stat.fin) state_nx = fcsg_pkg::ST_IDLE;
					else state_nx = fcsg_pkg::ST_SHRINK;
				end
			end
			fcsg_pkg::ST_EMIT_M: begin
				if (stat.slot_free) begin
					if (stat.has_extra) state_nx = fcsg_pkg::ST_EMIT_XP;
					else if (stat.fin) state_nx = fcsg_pkg::ST_IDLE;
					else state_nx = fcsg_pkg::ST_SHRINK;
				end
			end
			fcsg_pkg::ST_EMIT_XP: begin
				if (stat.slot_free) state_nx = fcsg_pkg::ST_EMIT_XM;
			end
			fcsg_pkg::ST_EMIT_XM: begin
				if (stat.slot_free) begin
					if (stat.fin) state_nx = fcsg_pkg::ST_IDLE;
					else state_nx = fcsg_pkg::ST_SHRINK;
				end
			end
			default: state_nx = fcsg_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		ctrl        = '0;
		ctrl.sel    = fcsg_pkg::SEL_P;
		case (state_q)
			fcsg_pkg::ST_IDLE: begin
				ctrl.ready = 1'b1;
				ctrl.load  = stat.in_valid;
			end
			fcsg_pkg::ST_SHRINK: begin
				ctrl.step = !stat.ndx_zero && stat.gt;
			end
			fcsg_pkg::ST_EMIT_P: begin
				ctrl.emit   = stat.slot_free;
				ctrl.sel    = fcsg_pkg::SEL_P;
				ctrl.last   = stat.fin && stat.dy_zero;
				ctrl.commit = stat.slot_free && stat.dy_zero;
			end
			fcsg_pkg::ST_EMIT_M: begin
				ctrl.emit   = stat.slot_free;
				ctrl.sel    = fcsg_pkg::SEL_M;
				ctrl.last   = stat.fin && !stat.has_extra;
				ctrl.commit = stat.slot_free && !stat.has_extra;
			end
			fcsg_pkg::ST_EMIT_XP: begin
				ctrl.emit = stat.slot_free;
				ctrl.sel  = fcsg_pkg::SEL_XP;
			end
			fcsg_pkg::ST_EMIT_XM: begin
				ctrl.emit   = stat.slot_free;
				ctrl.sel    = fcsg_pkg::SEL_XM;
				ctrl.last   = stat.fin;
				ctrl.commit = stat.slot_free;
				ctrl.mark   = stat.slot_free;
			end
			default: ctrl.ready = 1'b0;
		endcase
	end
endmodule

// ----- design/fcsg_out_reg.sv -----
// Output word register with valid/ready handshake toward the span receiver.
// Depends on fcsg_pkg for the field width.
module fcsg_out_reg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               load,
	input  logic signed [fcsg_pkg::OUT_BITS-1:0] row_d,
	input  logic signed [fcsg_pkg::OUT_BITS-1:0] left_d,
	input  logic signed [fcsg_pkg::OUT_BITS-1:0] right_d,
	input  logic                               last_d,
	output logic                               slot_free,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [fcsg_pkg::OUT_BITS-1:0] span_row,
	output logic signed [fcsg_pkg::OUT_BITS-1:0] span_left,
	output logic signed [fcsg_pkg::OUT_BITS-1:0] span_right,
	output logic                               last_span
);
	logic                                valid_q;
	logic signed [fcsg_pkg::OUT_BITS-1:0] row_q, left_q, right_q;
	logic                                last_q;

	assign slot_free = !valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && slot_free) begin
			row_q   <= row_d;
			left_q  <= left_d;
			right_q <= right_d;
			last_q  <= last_d;
		end
	end

	assign out_valid  = valid_q;
	assign span_row   = row_q;
	assign span_left  = left_q;
	assign span_right = right_q;
	assign last_span  = last_q;
endmodule

// ----- design/filled_circle_span_generator.sv -----
// Top level of the filled circle span generator: walk registers, span arithmetic, instances.
// Depends on fcsg_pkg, fcsg_dist_unit, fcsg_ctrl and fcsg_out_reg.
//
// Usage: a circle command word (center_x, center_y, radius) enters on the in_valid/in_ready
// channel. The block then emits, one word per cycle at best, the horizontal spans that fill
// the disc on the out_valid/out_ready channel; the final span of a command has last_span set.
// Radii above 30 are treated as 30; a zero radius yields one single-point span.
// Each walk step runs the shrink loop, which lowers the extent one decrement at a time
// while the shared distance compare still finds it outside the disc, and then emits its
// spans one by one. After a command is accepted the sequencer passes through the shrink
// state before the first span enters the output register; any radius other than zero
// always takes one extent decrement there first.
// in_ready is high only while no command is being walked; the next command can be taken
// while the final span still waits in the output register.
// When the receiver holds out_ready low the walk pauses at the next span and resumes
// without loss. Reset empties the output register and returns the sequencer to idle.
module filled_circle_span_generator (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic signed [fcsg_pkg::COORD_BITS-1:0] center_x,
	input  logic signed [fcsg_pkg::COORD_BITS-1:0] center_y,
	input  logic        [fcsg_pkg::RAD_BITS-1:0]   radius,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [fcsg_pkg::OUT_BITS-1:0]   span_row,
	output logic signed [fcsg_pkg::OUT_BITS-1:0]   span_left,
	output logic signed [fcsg_pkg::OUT_BITS-1:0]   span_right,
	output logic                                   last_span
);
	localparam int EB = fcsg_pkg::EXT_BITS;
	localparam int OB = fcsg_pkg::OUT_BITS;

	fcsg_pkg::stat_t stat;
	fcsg_pkg::ctrl_t ctrl;

	logic signed [fcsg_pkg::COORD_BITS-1:0] cx_q, cy_q;
	logic [fcsg_pkg::R2_BITS-1:0]  r2_q;
	logic [fcsg_pkg::RAD_BITS-1:0] r_sat;
	logic [EB-1:0] dx_q, dy_q, ndx_q, ndy_q, prev_q;
	logic          pvalid_q;
	logic          gt, slot_free;

	logic signed [OB-1:0] cx_ext, cy_ext, off, half, row_d, left_d, right_d;
	logic                 neg;

	assign r_sat = (radius > fcsg_pkg::RAD_BITS'(fcsg_pkg::MAX_RADIUS))
		? fcsg_pkg::RAD_BITS'(fcsg_pkg::MAX_RADIUS) : radius;

	// Center and squared radius are plain payload and need no reset.
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cx_q <= center_x;
			cy_q <= center_y;
			r2_q <= fcsg_pkg::R2_BITS'(r_sat) * fcsg_pkg::R2_BITS'(r_sat);
		end
	end

	// ndx/ndy hold the extent and offset of the next step, shrunk ahead of emission so
	// that the final span of a command is known when it is emitted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dx_q     <= '0;
			dy_q     <= '0;
			ndx_q    <= '0;
			ndy_q    <= '0;
			prev_q   <= '0;
			pvalid_q <= 1'b0;
		end else begin
			if (ctrl.load) begin
				dx_q     <= EB'(r_sat);
				ndx_q    <= EB'(r_sat);
				dy_q     <= '0;
				ndy_q    <= EB'(1);
				prev_q   <= '0;
				pvalid_q <= 1'b0;
			end
			if (ctrl.step) ndx_q <= ndx_q - EB'(1);
			if (ctrl.commit) begin
				dx_q  <= ndx_q;
				dy_q  <= ndy_q;
				ndy_q <= ndy_q + EB'(1);
			end
			if (ctrl.mark) begin
				prev_q   <= dx_q;
				pvalid_q <= 1'b1;
			end
		end
	end

	fcsg_dist_unit u_dist (
		.dx (ndx_q),
		.dy (ndy_q),
		.r2 (r2_q),
		.gt (gt)
	);

	always_comb begin
		stat.in_valid  = in_valid;
		stat.gt        = gt;
		stat.ndx_zero  = (ndx_q == '0);
		// With the extent at zero the compare reduces to r^2 < dy^2, which ends the walk.
		stat.fin       = ((ndx_q == '0) && gt) || (ndx_q < ndy_q);
		stat.has_extra = (!pvalid_q || (prev_q != dx_q)) && (dy_q != '0) && (dy_q != dx_q);
		stat.dy_zero   = (dy_q == '0);
		stat.slot_free = slot_free;
	end

	fcsg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign in_ready = ctrl.ready;

	always_comb begin
		cx_ext = OB'(cx_q);
		cy_ext = OB'(cy_q);
		case (ctrl.sel)
			fcsg_pkg::SEL_P: begin
				off  = $signed({{(OB-EB){1'b0}}, dy_q});
				half = $signed({{(OB-EB){1'b0}}, dx_q});
				neg  = 1'b0;
			end
			fcsg_pkg::SEL_M: begin
				off  = $signed({{(OB-EB){1'b0}}, dy_q});
				half = $signed({{(OB-EB){1'b0}}, dx_q});
				neg  = 1'b1;
			end
			fcsg_pkg::SEL_XP: begin
				off  = $signed({{(OB-EB){1'b0}}, dx_q});
				half = $signed({{(OB-EB){1'b0}}, dy_q});
				neg  = 1'b0;
			end
			fcsg_pkg::SEL_XM: begin
				off  = $signed({{(OB-EB){1'b0}}, dx_q});
				half = $signed({{(OB-EB){1'b0}}, dy_q});
				neg  = 1'b1;
			end
			default: begin
				off  = '0;
				half = '0;
				neg  = 1'b0;
			end
		endcase
		row_d   = neg ? (cy_ext - off) : (cy_ext + off);
		left_d  = cx_ext - half;
		right_d = cx_ext + half;
	end

	fcsg_out_reg u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (ctrl.emit),
		.row_d      (row_d),
		.left_d     (left_d),
		.right_d    (right_d),
		.last_d     (ctrl.last),
		.slot_free  (slot_free),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.span_row   (span_row),
		.span_left  (span_left),
		.span_right (span_right),
		.last_span  (last_span)
	);
endmodule

// ----- design/fcsg_checker.sv -----
// Port-level checker for the filled circle span generator, attached by bind.
// Depends on fcsg_pkg for widths and on the top level's port names.
module fcsg_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   in_valid,
	input logic                                   in_ready,
	input logic signed [fcsg_pkg::COORD_BITS-1:0] center_x,
	input logic signed [fcsg_pkg::COORD_BITS-1:0] center_y,
	input logic        [fcsg_pkg::RAD_BITS-1:0]   radius,
	input logic                                   out_valid,
	input logic                                   out_ready,
	input logic signed [fcsg_pkg::OUT_BITS-1:0]   span_row,
	input logic signed [fcsg_pkg::OUT_BITS-1:0]   span_left,
	input logic signed [fcsg_pkg::OUT_BITS-1:0]   span_right,
	input logic                                   last_span
);
	// A stalled output word holds its contents.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(span_row) && $stable(span_left)
			&& $stable(span_right) && $stable(last_span))
		else $error("stalled output word changed");

	// Once a command is taken the walker is busy for at least the next cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a command");

	// A span that is not the last leaves the rest of its command still in progress.
	a_busy_mid_command: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_span |-> !in_ready)
		else $error("ready for a new command before the last span");

	// Every span is symmetric about the center column, so it is ordered and of odd width.
	a_span_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (span_left <= span_right) && (span_left[0] == span_right[0]))
		else $error("malformed span");
endmodule

bind filled_circle_span_generator fcsg_checker u_fcsg_checker (.*);

// ----- dv/filled_circle_span_generator_tb.sv -----
// Self-checking testbench for filled_circle_span_generator: directed circles, then random ones.
// Depends on fcsg_pkg and the design top level; spans are checked against an in-bench predictor.
// Both handshakes idle in random bursts, and one long receiver hold-off fills the block up.
module filled_circle_span_generator_tb;

	localparam int HALF_PERIOD   = 4;
	localparam int RESET_CYCLES  = 5;
	localparam int RANDOM_CMDS   = 80;
	localparam int CALM_FROM     = 65;
	localparam int HOLD_AT       = 20;
	localparam int LONG_HOLD     = 400;
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int REPORT_LIMIT  = 10;
	localparam int DIRECTED_ROWS = 21;

	typedef logic signed [fcsg_pkg::COORD_BITS-1:0] coord_t;
	typedef logic signed [fcsg_pkg::OUT_BITS-1:0]   span_coord_t;
	typedef logic        [fcsg_pkg::RAD_BITS-1:0]   rad_t;

	typedef struct packed {
		span_coord_t row;
		span_coord_t left;
		span_coord_t right;
		logic        last;
	} span_t;

	// One directed circle. Rows with a known answer carry their single span.
	typedef struct packed {
		coord_t      cx;
		coord_t      cy;
		rad_t        r;
		logic        known;
		span_coord_t row;
		span_coord_t left;
		span_coord_t right;
	} circle_row_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	coord_t      center_x;
	coord_t      center_y;
	rad_t        radius;
	logic        out_valid;
	logic        out_ready;
	span_coord_t span_row;
	span_coord_t span_left;
	span_coord_t span_right;
	logic        last_span;

	span_t       pending_spans[$];
	circle_row_t directed_circles[DIRECTED_ROWS];
	int          mismatches;
	int          cycle_count;
	logic        long_hold_req;
	logic        calm_tail;

	filled_circle_span_generator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.center_x   (center_x),
		.center_y   (center_y),
		.radius     (radius),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.span_row   (span_row),
		.span_left  (span_left),
		.span_right (span_right),
		.last_span  (last_span)
	);

	initial clk = 1'b0;
	always #HALF_PERIOD clk = ~clk;

	function automatic span_t make_span(input int row, input int cx, input int half);
		span_t s;
		s.row   = span_coord_t'(row);
		s.left  = span_coord_t'(cx - half);
		s.right = span_coord_t'(cx + half);
		s.last  = 1'b0;
		return s;
	endfunction

	// Walks the disc as the block does and queues every span it should emit, in order.
	function automatic void fill_circle_spans(input coord_t cx_in, input coord_t cy_in,
			input rad_t rad);
		span_t found[$];
		span_t s;
		int    cx;
		int    cy;
		int    r;
		int    r2;
		int    dx;
		int    dy;
		int    pair_dx;
		bit    paired;
		cx = cx_in;
		cy = cy_in;
		r = (rad > fcsg_pkg::MAX_RADIUS) ? fcsg_pkg::MAX_RADIUS : int'(rad);
		r2 = r * r;
		dx = r;
		dy = 0;
		pair_dx = 0;
		paired = 1'b0;
		while (dx >= dy) begin
			found.push_back(make_span(cy + dy, cx, dx));
			if (dy != 0)
				found.push_back(make_span(cy - dy, cx, dx));
			// The octant rows at cy +/- dx are drawn at most once per distinct extent, and only while 0 < dy < dx.
			if ((!paired || pair_dx != dx) && dy > 0 && dy != dx) begin
				found.push_back(make_span(cy + dx, cx, dy));
				found.push_back(make_span(cy - dx, cx, dy));
				pair_dx = dx;
				paired = 1'b1;
			end
			dy++;
			while (dx > 0 && r2 < dx * dx + dy * dy)
				dx--;
			// Only a zero radius leaves the walk this way.
			if (dx == 0 && dy > 0 && r2 < dy * dy)
				break;
		end
		foreach (found[i]) begin
			s = found[i];
			s.last = (i == found.size() - 1);
			pending_spans.push_back(s);
		end
	endfunction

	// Offers one command word and returns at the edge that accepts it.
	task automatic offer_circle(input circle_row_t c);
		span_t s;
		center_x <= c.cx;
		center_y <= c.cy;
		radius   <= c.r;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (c.known) begin
			s.row   = c.row;
			s.left  = c.left;
			s.right = c.right;
			s.last  = 1'b1;
			pending_spans.push_back(s);
		end else
			fill_circle_spans(c.cx, c.cy, c.r);
	endtask

	task automatic sender_gap();
		if (!calm_tail && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	initial begin : stimulus
		circle_row_t c;
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		center_x      <= '0;
		center_y      <= '0;
		radius        <= '0;
		long_hold_req = 1'b0;
		calm_tail     = 1'b0;
		mismatches    = 0;
		// cx, cy, radius, known, then the single span where the answer is plain.
		directed_circles = '{
			'{0,     0,     0,  1, 0,     0,     0},
			'{-2048, -2048, 0,  1, -2048, -2048, -2048},
			'{2047,  2047,  0,  1, 2047,  2047,  2047},
			'{-2048, 2047,  1,  1, 2047,  -2049, -2047},
			'{2047,  -2048, 1,  1, -2048, 2046,  2048},
			'{0,     0,     2,  0, 0, 0, 0},
			'{-1,    -1,    3,  0, 0, 0, 0},
			'{100,   -100,  4,  0, 0, 0, 0},
			'{-2048, -2048, 30, 0, 0, 0, 0},
			'{2047,  2047,  30, 0, 0, 0, 0},
			'{2047,  -2048, 31, 0, 0, 0, 0},
			'{-2048, 2047,  31, 0, 0, 0, 0},
			'{0,     0,     30, 0, 0, 0, 0},
			'{1365,  -1366, 5,  0, 0, 0, 0},
			'{-1366, 1365,  7,  0, 0, 0, 0},
			'{-2048, 0,     10, 0, 0, 0, 0},
			'{2047,  0,     15, 0, 0, 0, 0},
			'{0,     -2048, 16, 0, 0, 0, 0},
			'{0,     2047,  21, 0, 0, 0, 0},
			'{-7,    9,     29, 0, 0, 0, 0},
			'{64,    -64,   8,  0, 0, 0, 0}
		};
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_circles[i]) begin
			offer_circle(directed_circles[i]);
			sender_gap();
		end

		for (int n = 0; n < RANDOM_CMDS; n++) begin
			if (n == HOLD_AT)
				long_hold_req = 1'b1;
			if (n == CALM_FROM)
				calm_tail = 1'b1;
			c = '0;
			c.cx = coord_t'($urandom_range(0, 4095));
			c.cy = coord_t'($urandom_range(0, 4095));
			// Each center coordinate is put on a coordinate limit in a quarter of the commands.
			if ($urandom_range(0, 3) == 0)
				c.cx = $urandom_range(0, 1) ? coord_t'(2047) : coord_t'(-2048);
			if ($urandom_range(0, 3) == 0)
				c.cy = $urandom_range(0, 1) ? coord_t'(2047) : coord_t'(-2048);
			c.r = rad_t'($urandom_range(0, 31));
			offer_circle(c);
			sender_gap();
		end
		in_valid <= 1'b0;

		while (pending_spans.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_spans.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Receiver side: random stall bursts, plus one long hold-off on request.
	initial begin : receiver
		int stall_left;
		stall_left = 0;
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				stall_left = LONG_HOLD;
			end else if (stall_left == 0 && !calm_tail && $urandom_range(0, 9) == 0)
				stall_left = $urandom_range(1, 16);
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else
				out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : span_check
		span_t exp_span;
		if (arst_n && out_valid && out_ready) begin
			if (pending_spans.size() == 0) begin
				if (mismatches < REPORT_LIMIT)
					$display("Unexpected span word: row %0d left %0d right %0d last %0b",
						span_row, span_left, span_right, last_span);
				mismatches++;
			end else begin
				exp_span = pending_spans.pop_front();
				if (span_row !== exp_span.row || span_left !== exp_span.left ||
						span_right !== exp_span.right || last_span !== exp_span.last) begin
					if (mismatches < REPORT_LIMIT)
						$display({"Span mismatch: expected row %0d left %0d right %0d ",
							"last %0b, got row %0d left %0d right %0d last %0b"},
							exp_span.row, exp_span.left, exp_span.right, exp_span.last,
							span_row, span_left, span_right, last_span);
					mismatches++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial cycle_count = 0;

endmodule

// ----- filled_circle_span_generator.f -----
design/fcsg_pkg.sv
design/fcsg_dist_unit.sv
design/fcsg_ctrl.sv
design/fcsg_out_reg.sv
design/filled_circle_span_generator.sv
design/fcsg_checker.sv
dv/filled_circle_span_generator_tb.sv
